@@ design/rau_pkg.sv @@
// shared types and codes for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned DenW  = 63;

  localparam logic [2:0] OP_NORM  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_NEG   = 3'd3;
  localparam logic [2:0] OP_SCALE = 3'd4;
  localparam logic [2:0] OP_CMP   = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DEN = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [WordW-1:0] MinNeg = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] MaxPos = {1'b0, {(WordW-1){1'b1}}};

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [WordW-1:0] a_num;
    logic signed [WordW-1:0] a_den;
    logic signed [WordW-1:0] b_num;
    logic signed [WordW-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] res_num;
    logic [DenW-1:0]         res_den;
    logic [1:0]              order;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] opa;
    logic [WordW-1:0] opb;
  } req_t;

endpackage

@@ design/rau_div.sv @@
// iterative unsigned divider, one quotient bit per cycle
module rau_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rau_pkg::req_t            req_i,
  output logic                     done_o,
  output logic [rau_pkg::WordW-1:0] quo_o,
  output logic [rau_pkg::WordW-1:0] rem_o
);

  logic [rau_pkg::WordW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [rau_pkg::WordW:0] sh, df;

  assign sh = {rem_q, quo_q[rau_pkg::WordW-1]};
  assign df = sh - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.opa;
      dvs_d  = req_i.opb;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!df[rau_pkg::WordW]) begin
        rem_d = df[rau_pkg::WordW-1:0];
        quo_d = {quo_q[rau_pkg::WordW-2:0], 1'b1};
      end else begin
        rem_d = sh[rau_pkg::WordW-1:0];
        quo_d = {quo_q[rau_pkg::WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(rau_pkg::WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ design/rau_mul.sv @@
// iterative signed multiplier with range check, one bit per cycle
module rau_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rau_pkg::req_t            req_i,
  output logic                     done_o,
  output logic                     ovf_o,
  output logic [rau_pkg::WordW-1:0] res_o
);

  logic [rau_pkg::WordW-1:0] hi_q, hi_d, lo_q, lo_d, mcd_q, mcd_d;
  logic neg_q, neg_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [rau_pkg::WordW:0] sum;
  logic [rau_pkg::WordW-1:0] ma, mb;

  assign ma  = req_i.opa[rau_pkg::WordW-1] ? (~req_i.opa + 1'b1) : req_i.opa;
  assign mb  = req_i.opb[rau_pkg::WordW-1] ? (~req_i.opb + 1'b1) : req_i.opb;
  assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? mcd_q : '0)};

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    mcd_d  = mcd_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      hi_d   = '0;
      lo_d   = mb;
      mcd_d  = ma;
      neg_d  = req_i.opa[rau_pkg::WordW-1] ^ req_i.opb[rau_pkg::WordW-1];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[rau_pkg::WordW:1];
      lo_d  = {sum[0], lo_q[rau_pkg::WordW-1:1]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(rau_pkg::WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    mcd_q <= mcd_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign ovf_o  = (hi_q != '0) ||
                  (neg_q ? (lo_q > rau_pkg::MinNeg) : (lo_q > rau_pkg::MaxPos));
  assign res_o  = neg_q ? (~lo_q + 1'b1) : lo_q;

endmodule

@@ design/rational_arithmetic_unit.sv @@
// rational arithmetic unit top level: sequencer around a shared divider and multiplier
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   in_data_i  (rau_pkg::in_t)
//   out      output     out_valid_o/out_stall_i out_data_o (rau_pkg::out_t)
//
// every division and multiplication runs on its shared unit
// a transaction's duration is set by the gcd and continued-fraction walks,
// that is by how many divisions and multiplications they need
// the next transaction is taken once the sequencer is back in idle
// a finished result waits in the output register while out_stall_i is high
// reset clears the sequencer and the output valid
module rational_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rau_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rau_pkg::out_t  out_data_o
);

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_RA      = 6'd1;
  localparam logic [5:0] S_RA_DONE = 6'd2;
  localparam logic [5:0] S_RB      = 6'd3;
  localparam logic [5:0] S_RB_DONE = 6'd4;
  localparam logic [5:0] S_RED     = 6'd5;
  localparam logic [5:0] S_GCD     = 6'd6;
  localparam logic [5:0] S_GCD_W   = 6'd7;
  localparam logic [5:0] S_RED_D1  = 6'd8;
  localparam logic [5:0] S_RED_W1  = 6'd9;
  localparam logic [5:0] S_RED_D2  = 6'd10;
  localparam logic [5:0] S_RED_W2  = 6'd11;
  localparam logic [5:0] S_DISP    = 6'd12;
  localparam logic [5:0] S_SC_W    = 6'd13;
  localparam logic [5:0] S_ADD_D1  = 6'd14;
  localparam logic [5:0] S_ADD_W1  = 6'd15;
  localparam logic [5:0] S_ADD_D2  = 6'd16;
  localparam logic [5:0] S_ADD_W2  = 6'd17;
  localparam logic [5:0] S_M1      = 6'd18;
  localparam logic [5:0] S_M1_W    = 6'd19;
  localparam logic [5:0] S_M2      = 6'd20;
  localparam logic [5:0] S_M2_W    = 6'd21;
  localparam logic [5:0] S_M3      = 6'd22;
  localparam logic [5:0] S_M3_W    = 6'd23;
  localparam logic [5:0] S_CMP_D1  = 6'd24;
  localparam logic [5:0] S_CMP_W1  = 6'd25;
  localparam logic [5:0] S_CMP_D2  = 6'd26;
  localparam logic [5:0] S_CMP_W2  = 6'd27;
  localparam logic [5:0] S_OUT     = 6'd28;

  localparam int unsigned W = rau_pkg::WordW;

  logic [5:0] state_q, state_d, gret_q, gret_d, rret_q, rret_d;
  logic [2:0] op_q, op_d;
  logic [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0] gx_q, gx_d, gy_q, gy_d, rn_q, rn_d, rd_q, rd_d, rm_q, rm_d;
  logic [W-1:0] tq_q, tq_d, tr_q, tr_d, p1_q, p1_d;
  logic rneg_q, rneg_d, flip_q, flip_d;
  logic [1:0] st_q, st_d, ord_q, ord_d, cres;
  logic out_valid_q, out_valid_d;
  rau_pkg::out_t out_q, out_d;

  rau_pkg::req_t div_req, mul_req;
  logic div_done, mul_done, mul_ovf;
  logic [W-1:0] div_quo, div_rem, mul_res, sum, mag;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  rau_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .ovf_o  (mul_ovf),
    .res_o  (mul_res)
  );

  assign sum = p1_q + mul_res;
  assign mag = rn_q[W-1] ? (~rn_q + 1'b1) : rn_q;

  always_comb begin
    state_d = state_q;
    gret_d  = gret_q;
    rret_d  = rret_q;
    op_d    = op_q;
    an_d    = an_q;
    ad_d    = ad_q;
    bn_d    = bn_q;
    bd_d    = bd_q;
    gx_d    = gx_q;
    gy_d    = gy_q;
    rn_d    = rn_q;
    rd_d    = rd_q;
    rm_d    = rm_q;
    tq_d    = tq_q;
    tr_d    = tr_q;
    p1_d    = p1_q;
    rneg_d  = rneg_q;
    flip_d  = flip_q;
    st_d    = st_q;
    ord_d   = ord_q;
    cres    = rau_pkg::ORD_EQ;
    out_d   = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req = '0;
    mul_req = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_data_i.operation;
          an_d  = in_data_i.a_num;
          ad_d  = in_data_i.a_den;
          bn_d  = in_data_i.b_num;
          bd_d  = in_data_i.b_den;
          st_d  = rau_pkg::ST_OK;
          ord_d = rau_pkg::ORD_LT;
          rn_d  = '0;
          rd_d  = W'(1);
          if (in_data_i.operation > rau_pkg::OP_CMP) begin
            state_d = S_OUT;
          end else if (in_data_i.a_den[W-1] || in_data_i.a_den == '0 ||
                       ((in_data_i.operation == rau_pkg::OP_ADD ||
                         in_data_i.operation == rau_pkg::OP_SUB ||
                         in_data_i.operation == rau_pkg::OP_CMP) &&
                        (in_data_i.b_den[W-1] || in_data_i.b_den == '0))) begin
            st_d    = rau_pkg::ST_DEN;
            state_d = S_OUT;
          end else begin
            state_d = S_RA;
          end
        end
      end
      S_RA: begin
        rn_d    = an_q;
        rd_d    = ad_q;
        rret_d  = S_RA_DONE;
        state_d = S_RED;
      end
      S_RA_DONE: begin
        an_d = rn_q;
        ad_d = rd_q;
        if (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB || op_q == rau_pkg::OP_CMP) begin
          state_d = S_RB;
        end else begin
          state_d = S_DISP;
        end
      end
      S_RB: begin
        rn_d    = bn_q;
        rd_d    = bd_q;
        rret_d  = S_RB_DONE;
        state_d = S_RED;
      end
      S_RB_DONE: begin
        bn_d    = rn_q;
        bd_d    = rd_q;
        state_d = S_DISP;
      end
      S_RED: begin
        rneg_d  = rn_q[W-1];
        rm_d    = mag;
        gx_d    = mag;
        gy_d    = rd_q;
        gret_d  = S_RED_D1;
        state_d = S_GCD;
      end
      S_GCD: begin
        if (gy_q == '0) begin
          state_d = gret_q;
        end else begin
          div_req = '{start: 1'b1, opa: gx_q, opb: gy_q};
          state_d = S_GCD_W;
        end
      end
      S_GCD_W: begin
        if (div_done) begin
          gx_d    = gy_q;
          gy_d    = div_rem;
          state_d = S_GCD;
        end
      end
      S_RED_D1: begin
        div_req = '{start: 1'b1, opa: rm_q, opb: gx_q};
        state_d = S_RED_W1;
      end
      S_RED_W1: begin
        if (div_done) begin
          rm_d    = div_quo;
          state_d = S_RED_D2;
        end
      end
      S_RED_D2: begin
        div_req = '{start: 1'b1, opa: rd_q, opb: gx_q};
        state_d = S_RED_W2;
      end
      S_RED_W2: begin
        if (div_done) begin
          rd_d    = div_quo;
          rn_d    = rneg_q ? (~rm_q + 1'b1) : rm_q;
          state_d = rret_q;
        end
      end
      S_DISP: begin
        unique case (op_q)
          rau_pkg::OP_NORM: begin
            state_d = S_OUT;
          end
          rau_pkg::OP_NEG: begin
            if (an_q == rau_pkg::MinNeg) begin
              st_d = rau_pkg::ST_OVF;
            end else begin
              rn_d = ~an_q + 1'b1;
              rd_d = ad_q;
            end
            state_d = S_OUT;
          end
          rau_pkg::OP_SCALE: begin
            mul_req = '{start: 1'b1, opa: an_q, opb: bn_q};
            state_d = S_SC_W;
          end
          rau_pkg::OP_CMP: begin
            rn_d = '0;
            rd_d = W'(1);
            if (an_q[W-1] && !bn_q[W-1]) begin
              ord_d   = rau_pkg::ORD_LT;
              state_d = S_OUT;
            end else if (!an_q[W-1] && bn_q[W-1]) begin
              ord_d   = rau_pkg::ORD_GT;
              state_d = S_OUT;
            end else begin
              an_d    = an_q[W-1] ? (~an_q + 1'b1) : an_q;
              bn_d    = bn_q[W-1] ? (~bn_q + 1'b1) : bn_q;
              flip_d  = an_q[W-1];
              state_d = S_CMP_D1;
            end
          end
          rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            if (op_q == rau_pkg::OP_SUB && bn_q == rau_pkg::MinNeg) begin
              st_d    = rau_pkg::ST_OVF;
              state_d = S_OUT;
            end else begin
              if (op_q == rau_pkg::OP_SUB) begin
                bn_d = ~bn_q + 1'b1;
              end
              gx_d    = ad_q;
              gy_d    = bd_q;
              gret_d  = S_ADD_D1;
              state_d = S_GCD;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_SC_W: begin
        if (mul_done) begin
          if (mul_ovf) begin
            st_d    = rau_pkg::ST_OVF;
            state_d = S_OUT;
          end else begin
            rn_d    = mul_res;
            rd_d    = ad_q;
            rret_d  = S_OUT;
            state_d = S_RED;
          end
        end
      end
      S_ADD_D1: begin
        div_req = '{start: 1'b1, opa: bd_q, opb: gx_q};
        state_d = S_ADD_W1;
      end
      S_ADD_W1: begin
        if (div_done) begin
          tq_d    = div_quo;
          state_d = S_ADD_D2;
        end
      end
      S_ADD_D2: begin
        div_req = '{start: 1'b1, opa: ad_q, opb: gx_q};
        state_d = S_ADD_W2;
      end
      S_ADD_W2: begin
        if (div_done) begin
          tr_d    = div_quo;
          state_d = S_M1;
        end
      end
      S_M1: begin
        mul_req = '{start: 1'b1, opa: an_q, opb: tq_q};
        state_d = S_M1_W;
      end
      S_M1_W: begin
        if (mul_done) begin
          if (mul_ovf) begin
            st_d    = rau_pkg::ST_OVF;
            state_d = S_OUT;
          end else begin
            p1_d    = mul_res;
            state_d = S_M2;
          end
        end
      end
      S_M2: begin
        mul_req = '{start: 1'b1, opa: bn_q, opb: tr_q};
        state_d = S_M2_W;
      end
      S_M2_W: begin
        if (mul_done) begin
          if (mul_ovf || ((p1_q[W-1] == mul_res[W-1]) && (sum[W-1] != p1_q[W-1]))) begin
            st_d    = rau_pkg::ST_OVF;
            state_d = S_OUT;
          end else begin
            rn_d    = sum;
            state_d = S_M3;
          end
        end
      end
      S_M3: begin
        mul_req = '{start: 1'b1, opa: ad_q, opb: tq_q};
        state_d = S_M3_W;
      end
      S_M3_W: begin
        if (mul_done) begin
          if (mul_ovf || mul_res == '0 || mul_res[W-1]) begin
            st_d    = rau_pkg::ST_OVF;
            state_d = S_OUT;
          end else begin
            rd_d    = mul_res;
            rret_d  = S_OUT;
            state_d = S_RED;
          end
        end
      end
      S_CMP_D1: begin
        div_req = '{start: 1'b1, opa: an_q, opb: ad_q};
        state_d = S_CMP_W1;
      end
      S_CMP_W1: begin
        if (div_done) begin
          tq_d    = div_quo;
          tr_d    = div_rem;
          state_d = S_CMP_D2;
        end
      end
      S_CMP_D2: begin
        div_req = '{start: 1'b1, opa: bn_q, opb: bd_q};
        state_d = S_CMP_W2;
      end
      S_CMP_W2: begin
        if (div_done) begin
          if (tq_q != div_quo || tr_q == '0 || div_rem == '0) begin
            if (tq_q != div_quo) begin
              cres = (tq_q < div_quo) ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
            end else if (tr_q == '0 && div_rem != '0) begin
              cres = rau_pkg::ORD_LT;
            end else if (tr_q != '0 && div_rem == '0) begin
              cres = rau_pkg::ORD_GT;
            end else begin
              cres = rau_pkg::ORD_EQ;
            end
            ord_d   = flip_q ? (rau_pkg::ORD_GT - cres) : cres;
            state_d = S_OUT;
          end else begin
            an_d    = ad_q;
            ad_d    = tr_q;
            bn_d    = bd_q;
            bd_d    = div_rem;
            flip_d  = !flip_q;
            state_d = S_CMP_D1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.status = st_q;
          if (st_q != rau_pkg::ST_OK) begin
            out_d.res_num = '0;
            out_d.res_den = rau_pkg::DenW'(1);
            out_d.order   = rau_pkg::ORD_LT;
          end else begin
            out_d.res_num = rn_q;
            out_d.res_den = rd_q[rau_pkg::DenW-1:0];
            out_d.order   = ord_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gret_q <= gret_d;
    rret_q <= rret_d;
    op_q   <= op_d;
    an_q   <= an_d;
    ad_q   <= ad_d;
    bn_q   <= bn_d;
    bd_q   <= bd_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    rn_q   <= rn_d;
    rd_q   <= rd_d;
    rm_q   <= rm_d;
    tq_q   <= tq_d;
    tr_q   <= tr_d;
    p1_q   <= p1_d;
    rneg_q <= rneg_d;
    flip_q <= flip_d;
    st_q   <= st_d;
    ord_q  <= ord_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted transaction did not make the unit busy");

  a_err_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != rau_pkg::ST_OK) |->
      (out_data_o.res_num == '0 && out_data_o.res_den == rau_pkg::DenW'(1)))
    else $error("error result carries a fraction");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.res_den != '0))
    else $error("result denominator is zero");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_done && mul_done))
    else $error("divider and multiplier finished together");
`endif

endmodule

@@ verif/rational_arithmetic_unit_checker.sv @@
// checker for the rational arithmetic unit: predicts each result and compares it
`timescale 1ns / 100ps
module rational_arithmetic_unit_checker
  import rau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_stall_i,
  input  in_t   in_data_i,
  input  logic  out_valid_i,
  input  logic  out_stall_i,
  input  out_t  out_data_i,
  output int    fail_count_o,
  output int    pending_o
);

  out_t expected_results[$];

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic den_positive(logic [63:0] d);
    return d != 0 && !d[63];
  endfunction

  function automatic void reduce_frac(ref logic [63:0] n, ref logic [63:0] d);
    logic        neg;
    logic [63:0] m, g;
    neg = n[63];
    m = neg ? -n : n;
    g = gcd_of(m, d);
    if (g == 0) g = 1;
    m = m / g;
    d = d / g;
    n = neg ? -m : m;
  endfunction

  function automatic logic mul_fits(logic [63:0] x, logic [63:0] y, output logic [63:0] p);
    logic        neg;
    logic [63:0] mx, my, lim;
    mx = x[63] ? -x : x;
    my = y[63] ? -y : y;
    neg = x[63] != y[63];
    p = 0;
    if (mx == 0 || my == 0) return 1'b1;
    lim = neg ? MinNeg : MaxPos;
    if (mx > lim / my) return 1'b0;
    p = mx * my;
    if (neg) p = -p;
    return 1'b1;
  endfunction

  function automatic logic add_fits(logic [63:0] x, logic [63:0] y, output logic [63:0] s);
    s = x + y;
    return !(x[63] == y[63] && s[63] != x[63]);
  endfunction

  function automatic logic [1:0] order_of_mags(logic [63:0] ln, logic [63:0] ld,
                                               logic [63:0] rn, logic [63:0] rd);
    logic        flip;
    logic [1:0]  r;
    logic [63:0] lq, rq, lr, rr;
    flip = 1'b0;
    forever begin
      lq = ln / ld;
      rq = rn / rd;
      if (lq != rq) begin
        r = lq < rq ? ORD_LT : ORD_GT;
        break;
      end
      lr = ln % ld;
      rr = rn % rd;
      if (lr == 0 || rr == 0) begin
        r = ORD_EQ;
        if (lr == 0 && rr != 0) r = ORD_LT;
        else if (lr != 0 && rr == 0) r = ORD_GT;
        break;
      end
      ln = ld; ld = lr;
      rn = rd; rd = rr;
      flip = !flip;
    end
    return flip ? 2'd2 - r : r;
  endfunction

  function automatic out_t rational_result(in_t t);
    out_t        r;
    logic [63:0] an, ad, bn, bd, rn, rd, g, lf, rf, p1, p2, s, d;
    logic        useb, ok;
    logic [1:0]  c;
    an = t.a_num; ad = t.a_den; bn = t.b_num; bd = t.b_den;
    rn = 0; rd = 1;
    r.order = ORD_LT;
    r.status = ST_OK;
    useb = t.operation inside {OP_ADD, OP_SUB, OP_CMP};
    if (t.operation <= OP_CMP) begin
      if (!den_positive(ad) || (useb && !den_positive(bd))) begin
        r.status = ST_DEN;
      end else begin
        reduce_frac(an, ad);
        if (useb) reduce_frac(bn, bd);
        case (t.operation)
          OP_NORM: begin
            rn = an; rd = ad;
          end
          OP_NEG: begin
            if (an == MinNeg) r.status = ST_OVF;
            else begin rn = -an; rd = ad; end
          end
          OP_SCALE: begin
            if (!mul_fits(an, bn, p1)) r.status = ST_OVF;
            else begin rn = p1; rd = ad; reduce_frac(rn, rd); end
          end
          OP_CMP: begin
            if (an[63] && !bn[63]) r.order = ORD_LT;
            else if (!an[63] && bn[63]) r.order = ORD_GT;
            else begin
              c = order_of_mags(an[63] ? -an : an, ad, bn[63] ? -bn : bn, bd);
              r.order = an[63] ? 2'd2 - c : c;
            end
          end
          default: begin
            if (t.operation == OP_SUB) begin
              if (bn == MinNeg) r.status = ST_OVF;
              else bn = -bn;
            end
            if (r.status == ST_OK) begin
              g = gcd_of(ad, bd);
              if (g == 0) g = 1;
              lf = bd / g;
              rf = ad / g;
              ok = mul_fits(an, lf, p1);
              if (ok) ok = mul_fits(bn, rf, p2);
              if (ok) ok = add_fits(p1, p2, s);
              if (ok) ok = mul_fits(ad, lf, d);
              if (ok) ok = den_positive(d);
              if (!ok) r.status = ST_OVF;
              else begin rn = s; rd = d; reduce_frac(rn, rd); end
            end
          end
        endcase
        if (r.status != ST_OK) begin rn = 0; rd = 1; r.order = ORD_LT; end
      end
    end
    r.res_num = rn;
    r.res_den = rd[62:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int   errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(rational_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.res_num !== want.res_num) begin
            $error("res_num expected %0d actual %0d", want.res_num, out_data_i.res_num);
            errs++;
          end
          if (out_data_i.res_den !== want.res_den) begin
            $error("res_den expected %0d actual %0d", want.res_den, out_data_i.res_den);
            errs++;
          end
          if (out_data_i.order !== want.order) begin
            $error("order expected %0d actual %0d", want.order, out_data_i.order);
            errs++;
          end
          if (out_data_i.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data_i.status);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ verif/rational_arithmetic_unit_tb.sv @@
// testbench top for the rational arithmetic unit: stimulus, stalls and verdict
`timescale 1ns / 100ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  int   fail_count, pending;
  logic hold_off = 1'b0;

  always #1 clk_i = ~clk_i;

  rational_arithmetic_unit dut (.*);

  rational_arithmetic_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_small(int hi);
    logic [63:0] v;
    v = $urandom_range(0, hi);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return rand_word();
      1: return rand_word() >> $urandom_range(1, 63);
      2: return rand_small(1000);
      3: return $urandom_range(0, 1) ? MinNeg : MaxPos;
      default: return rand_small(50);
    endcase
  endfunction

  function automatic logic [63:0] rand_den();
    case ($urandom_range(0, 19))
      0: return rand_small(3);
      1: return rand_word();
      2: return MaxPos;
      3, 4, 5: return rand_word() >> $urandom_range(1, 63);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  task automatic send(logic [2:0] op, logic [63:0] an, logic [63:0] ad,
                      logic [63:0] bn, logic [63:0] bd);
    in_data_i <= '{op, an, ad, bn, bd};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    int g;
    logic [2:0] op;
    op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    send(op, rand_operand(), rand_den(), rand_operand(), rand_den());
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(0, 3) == 0 ? 1'b1 : 1'b0);
  end

  initial begin
    #100000000;
    $display("rational_arithmetic_unit_tb failed");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(OP_NORM, 64'd6, 64'd4, 0, 1);
    send(OP_NORM, MinNeg, 64'd2, 0, 1);
    send(OP_NORM, 64'd0, 64'd7, 0, 1);
    send(OP_NORM, 64'd5, 64'd0, 0, 1);
    send(OP_NORM, 64'd5, MinNeg, 0, 1);
    send(OP_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
    send(OP_ADD, MaxPos, 64'd1, 64'd1, 64'd1);
    send(OP_ADD, 64'd1, 64'd3, 64'd1, -64'd1);
    send(OP_ADD, 64'd1, MaxPos, 64'd1, MaxPos - 1);
    send(OP_SUB, 64'd3, 64'd4, 64'd1, 64'd4);
    send(OP_SUB, 64'd0, 64'd1, MinNeg, 64'd1);
    send(OP_SUB, MinNeg, 64'd1, 64'd1, 64'd1);
    send(OP_NEG, MinNeg, 64'd1, 0, 0);
    send(OP_NEG, MinNeg, 64'd2, 0, 0);
    send(OP_NEG, MaxPos, 64'd3, 0, 0);
    send(OP_SCALE, 64'd3, 64'd9, 64'd6, -64'd5);
    send(OP_SCALE, MaxPos, 64'd1, 64'd2, 0);
    send(OP_SCALE, MinNeg, 64'd1, -64'd1, 0);
    send(OP_CMP, 64'd1, 64'd3, 64'd2, 64'd6);
    send(OP_CMP, -64'd1, 64'd2, 64'd1, 64'd3);
    send(OP_CMP, 64'd355, 64'd113, 64'd22, 64'd7);
    send(OP_CMP, -64'd355, 64'd113, -64'd22, 64'd7);
    send(OP_CMP, MaxPos, MaxPos - 1, MaxPos - 1, MaxPos - 2);
    send(3'd6, MaxPos, 64'd1, 64'd1, 64'd1);
    send(3'd7, 64'd1, 64'd0, 64'd1, 64'd0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    hold_off <= 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      repeat (6) send_random();
    join
    for (int i = 0; i < 190; i++) send_random();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < 190; i++) send_random();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rational_arithmetic_unit_tb passed");
    end else begin
      $display("rational_arithmetic_unit_tb failed");
    end
    $finish;
  end

endmodule
